// ----- sv/tmf_pkg.sv -----
package tmf_pkg;

  // Input item kinds carried on the slave tuser line.
  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_NONE   = 2'd3
  } reg_e;

  localparam int unsigned PIX_W = 16;
  localparam int unsigned WIN_W = 4;
  localparam int unsigned DIM_W = 11;

  localparam logic [WIN_W-1:0] WIN_MIN   = 4'd3;
  localparam logic [WIN_W-1:0] WIN_RESET = 4'd5;
  localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

  // Per-item control that travels along the pipeline with each pixel.
  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic             filt;
    logic             last;
    logic [WIN_W-1:0] wslot;
    logic [WIN_W-1:0] win;
  } meta_t;

  // Force the window odd and into 3..top, where top is odd.
  function automatic logic [WIN_W-1:0] fit_window(input logic [WIN_W-1:0] v,
                                                  input logic [WIN_W-1:0] top);
    logic [WIN_W-1:0] w;
    w = v;
    if (w < WIN_MIN) w = WIN_MIN;
    if (!w[0]) w = w + 4'd1;
    if (w > top) w = top;
    return w;
  endfunction

  function automatic logic [DIM_W-1:0] fit_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W:0] top);
    logic [DIM_W-1:0] d;
    d = v;
    if (v == '0) d = 11'd1;
    else if ({1'b0, v} > top) d = top[DIM_W-1:0];
    return d;
  endfunction

endpackage

// ----- sv/tmf_ram.sv -----
module tmf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/tmf_ctrl.sv -----
module tmf_ctrl #(
  parameter int unsigned MAX_WINDOW = 9,
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned AW         = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tmf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tmf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             clear_i,
  input  logic                             pixel_i,
  input  logic [tmf_pkg::PIX_W-1:0]        px_i,
  output logic [AW-1:0]                    addr_o,
  output tmf_pkg::meta_t                   meta_o
);
  import tmf_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned XW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
  localparam int unsigned YW = (RW + 1 > DIM_W) ? RW + 1 : DIM_W;
  localparam logic [WIN_W-1:0] WIN_TOP =
    WIN_W'((MAX_WINDOW % 2 == 0) ? MAX_WINDOW - 1 : MAX_WINDOW);
  localparam logic [DIM_W:0] W_TOP = (MAX_WIDTH  > 2047) ? 12'd2047 : (DIM_W+1)'(MAX_WIDTH);
  localparam logic [DIM_W:0] H_TOP = (MAX_HEIGHT > 2047) ? 12'd2047 : (DIM_W+1)'(MAX_HEIGHT);

  logic [WIN_W-1:0] win_q, win_d;
  logic [DIM_W-1:0] width_q, width_d, height_q, height_d;
  logic [CW-1:0]    col_q, col_d;
  logic [RW-1:0]    row_q, row_d;
  logic [AW-1:0]    base_q, base_d;
  logic [WIN_W-1:0] slot_q, slot_d, held_q, held_d;

  logic [CW-1:0]    col_use;
  logic [RW-1:0]    row_use;
  logic [AW-1:0]    base_use;
  logic [WIN_W-1:0] slot_use;
  logic             col_end, row_end, wrap;

  always_comb begin
    wrap     = ({{(XW-CW){1'b0}}, col_q} >= {{(XW-DIM_W){1'b0}}, width_q}) ||
               ({{(YW-RW){1'b0}}, row_q} >= {{(YW-DIM_W){1'b0}}, height_q});
    col_use  = wrap ? '0 : col_q;
    row_use  = wrap ? '0 : row_q;
    base_use = wrap ? '0 : base_q;
    slot_use = (slot_q >= win_q) ? '0 : slot_q;
    col_end  = ({{(XW-CW){1'b0}}, col_use} + XW'(1)) >= {{(XW-DIM_W){1'b0}}, width_q};
    row_end  = ({{(YW-RW){1'b0}}, row_use} + YW'(1)) >= {{(YW-DIM_W){1'b0}}, height_q};

    addr_o       = base_use + {{(AW-CW){1'b0}}, col_use};
    meta_o.px    = px_i;
    meta_o.filt  = ({1'b0, held_q} + 5'd1) >= {1'b0, win_q};
    meta_o.last  = col_end && row_end;
    meta_o.wslot = slot_use;
    meta_o.win   = win_q;
  end

  always_comb begin
    win_d    = win_q;
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    base_d   = base_q;
    slot_d   = slot_q;
    held_d   = held_q;
    if (cfg_we_i) begin
      case (reg_e'(cfg_index_i))
        REG_WINDOW: win_d    = fit_window(cfg_data_i[WIN_W-1:0], WIN_TOP);
        REG_WIDTH:  width_d  = fit_dim(cfg_data_i, W_TOP);
        REG_HEIGHT: height_d = fit_dim(cfg_data_i, H_TOP);
        default:    ;
      endcase
    end
    if (clear_i || (cfg_we_i && reg_e'(cfg_index_i) != REG_NONE)) begin
      col_d  = '0;
      row_d  = '0;
      base_d = '0;
      slot_d = '0;
      held_d = '0;
    end else if (pixel_i) begin
      if (col_end) begin
        col_d = '0;
        if (row_end) begin
          row_d  = '0;
          base_d = '0;
          slot_d = (({1'b0, slot_use} + 5'd1) >= {1'b0, win_q}) ? '0 : slot_use + 4'd1;
          held_d = (({1'b0, held_q} + 5'd1) < {1'b0, win_q}) ? held_q + 4'd1 : held_q;
        end else begin
          row_d  = row_use + RW'(1);
          base_d = base_use + AW'(MAX_WIDTH);
          slot_d = slot_use;
        end
      end else begin
        col_d  = col_use + CW'(1);
        row_d  = row_use;
        base_d = base_use;
        slot_d = slot_use;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= fit_window(WIN_RESET, WIN_TOP);
      width_q  <= fit_dim(DIM_RESET, W_TOP);
      height_q <= fit_dim(DIM_RESET, H_TOP);
      col_q    <= '0;
      row_q    <= '0;
      base_q   <= '0;
      slot_q   <= '0;
      held_q   <= '0;
    end else begin
      win_q    <= win_d;
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      base_q   <= base_d;
      slot_q   <= slot_d;
      held_q   <= held_d;
    end
  end

endmodule

// ----- sv/tmf_median.sv -----
module tmf_median #(
  parameter int unsigned MAX_WINDOW = 9,
  parameter int unsigned PW         = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       valid_i,
  input  tmf_pkg::meta_t             meta_i,
  input  logic [MAX_WINDOW*PW-1:0]   vals_i,
  output logic                       valid_o,
  output logic [tmf_pkg::PIX_W-1:0]  pixel_o,
  output logic                       filt_o,
  output logic                       last_o
);
  import tmf_pkg::*;

  // Compare stage: lt_q[i][j] says slot j ranks below slot i.
  logic                   va_q;
  meta_t                  ma_q;
  logic [MAX_WINDOW-1:0]  use_q;
  logic [MAX_WINDOW-1:0]  lt_d [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]  lt_q [MAX_WINDOW];
  logic [PW-1:0]          va_vals_q [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]  use_d;

  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      use_d[i] = (WIN_W+1)'(i) < {1'b0, meta_i.win};
      for (int j = 0; j < MAX_WINDOW; j++) begin
        lt_d[i][j] = ((WIN_W+1)'(j) < {1'b0, meta_i.win}) &&
                     ((vals_i[j*PW +: PW] < vals_i[i*PW +: PW]) ||
                      ((vals_i[j*PW +: PW] == vals_i[i*PW +: PW]) && (j < i)));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (adv_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ma_q  <= meta_i;
      use_q <= use_d;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        lt_q[i]      <= lt_d[i];
        va_vals_q[i] <= vals_i[i*PW +: PW];
      end
    end
  end

  // Rank stage: the slot whose rank equals half the window is the median.
  logic             vo_q;
  logic [PIX_W-1:0] pix_q, pix_d;
  logic             filt_q, last_q;
  logic [PW-1:0]    med;
  logic [WIN_W-1:0] rank;

  always_comb begin
    med = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      rank = WIN_W'($countones(lt_q[i]));
      if (use_q[i] && rank == (ma_q.win >> 1)) med = med | va_vals_q[i];
    end
    pix_d = ma_q.filt ? PIX_W'(med) : ma_q.px;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (adv_i) begin
      vo_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pix_q  <= pix_d;
      filt_q <= ma_q.filt;
      last_q <= ma_q.last;
    end
  end

  assign valid_o = vo_q;
  assign pixel_o = pix_q;
  assign filt_o  = filt_q;
  assign last_o  = last_q;

endmodule

// ----- sv/temporal_median_filter_core.sv -----
// Each accepted pixel passes the memory read, compare and rank registers.
// Throughput: one pixel per cycle; the whole pipeline advances together and
// holds while the output register is full and not taken.
// Reset (rst_ni low, asynchronous): window 5, frame 1024 x 1024, empty history.
// The frame memories are not cleared; a median only reads written entries.
module temporal_median_filter_core #(
  parameter int unsigned MAX_WINDOW = 9,
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Slave stream: tdata = pixel[15:0]; tuser = kind.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,
  input  logic                           s_axis_tuser,
  // Master stream: tdata = pixel_out[15:0]; tuser = filtered; tlast = last_of_frame.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast,
  // Configuration write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tmf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tmf_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tmf_pkg::*;

  // Stored pixel width: at most sixteen bits are kept.
  localparam int unsigned PW    = (PIXEL_BITS > PIX_W) ? PIX_W : PIXEL_BITS;
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);

  // The pipeline moves as one: it advances whenever the output register is
  // free or its current transfer completes this cycle.
  logic adv;
  logic in_acc, pix_acc, clr_acc, cfg_we;
  logic [PIX_W-1:0] px_masked;
  logic [AW-1:0] addr;
  meta_t meta0;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready_o   = 1'b1;
  assign cfg_we        = cfg_valid_i;
  assign in_acc        = s_axis_tvalid && adv;
  assign pix_acc       = in_acc && (kind_e'(s_axis_tuser) == KIND_PIXEL);
  assign clr_acc       = in_acc && (kind_e'(s_axis_tuser) == KIND_CLEAR);
  assign px_masked     = PIX_W'(s_axis_tdata[PW-1:0]);

  tmf_ctrl #(
    .MAX_WINDOW (MAX_WINDOW),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .clear_i     (clr_acc),
    .pixel_i     (pix_acc),
    .px_i        (px_masked),
    .addr_o      (addr),
    .meta_o      (meta0)
  );

  // One bank per frame slot, so every slot of the window is read in the same
  // cycle. The slot being written is not read back: its value is the pixel
  // itself, substituted once the other banks return data.
  logic [PW-1:0]            rdata [MAX_WINDOW];
  logic [MAX_WINDOW*PW-1:0] vals;

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_bank
    tmf_ram #(
      .WIDTH (PW),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (pix_acc && (meta0.wslot == WIN_W'(g))),
      .waddr_i (addr),
      .wdata_i (px_masked[PW-1:0]),
      .re_i    (adv),
      .raddr_i (addr),
      .rdata_o (rdata[g])
    );
  end

  // Memory read stage: metadata registered alongside the bank read data.
  logic  s1_valid_q;
  meta_t s1_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= pix_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_meta_q <= meta0;
    end
  end

  always_comb begin
    for (int g = 0; g < MAX_WINDOW; g++) begin
      vals[g*PW +: PW] = (s1_meta_q.wslot == WIN_W'(g)) ? s1_meta_q.px[PW-1:0] : rdata[g];
    end
  end

  // Compare and rank stages; the rank stage register drives the master side.
  tmf_median #(
    .MAX_WINDOW (MAX_WINDOW),
    .PW         (PW)
  ) u_median (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s1_valid_q),
    .meta_i  (s1_meta_q),
    .vals_i  (vals),
    .valid_o (m_axis_tvalid),
    .pixel_o (m_axis_tdata),
    .filt_o  (m_axis_tuser),
    .last_o  (m_axis_tlast)
  );

endmodule

// ----- verif/temporal_median_filter_checker.sv -----
module temporal_median_filter_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,
  input  logic                           s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [15:0]                    m_axis_tdata,
  input  logic                           m_axis_tuser,
  input  logic                           m_axis_tlast,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_o,
  input  logic [tmf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tmf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             errors_o,
  output int                             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tmf_pkg::*;

  localparam int unsigned PLANE     = 1024 * 1024;
  localparam int unsigned EXP_DEPTH = 64;

  typedef struct {
    logic [15:0] px;
    logic        filt;
    logic        last;
  } pix_result_t;

  // Expected results in a ring, oldest at exp_head.
  pix_result_t      exp_mem [EXP_DEPTH];
  int unsigned      exp_head = 0;
  int unsigned      exp_tail = 0;
  int unsigned      exp_count = 0;
  logic [15:0]      history_mem[int unsigned];
  logic [WIN_W-1:0] win_size;
  logic [DIM_W-1:0] width_px, height_px;
  int unsigned      slot, held, col, row;

  initial errors_o = 0;
  assign pending_o = int'(exp_count);

  task automatic empty_ring();
    slot = 0;
    held = 0;
    col  = 0;
    row  = 0;
  endtask

  task automatic apply_register(input reg_e idx, input logic [CFG_DATA_W-1:0] data);
    logic [WIN_W-1:0] w;
    case (idx)
      REG_WINDOW: begin
        w = data[WIN_W-1:0];
        if (w < 4'd3) w = 4'd3;
        if (!w[0]) w = w + 4'd1;
        if (w > 4'd9) w = 4'd9;
        win_size = w;
      end
      REG_WIDTH:  width_px  = (data == '0) ? DIM_W'(1) :
                              (data > DIM_W'(1024)) ? DIM_W'(1024) : data;
      REG_HEIGHT: height_px = (data == '0) ? DIM_W'(1) :
                              (data > DIM_W'(1024)) ? DIM_W'(1024) : data;
      default: return;
    endcase
    empty_ring();
  endtask

  task automatic predict_pixel(input logic [15:0] px);
    logic [15:0] sorted[9];
    logic [15:0] v;
    pix_result_t r;
    int unsigned pos, j;
    if (col >= width_px || row >= height_px) begin
      col = 0;
      row = 0;
    end
    if (slot >= win_size) slot = 0;
    pos = row * 1024 + col;
    history_mem[slot * PLANE + pos] = px;
    if (held + 1 >= win_size) begin
      // Insertion sort over the whole ring at this position.
      for (int i = 0; i < win_size; i++) begin
        v = history_mem[i * PLANE + pos];
        j = i;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      r.px   = sorted[win_size / 2];
      r.filt = 1'b1;
    end else begin
      r.px   = px;
      r.filt = 1'b0;
    end
    r.last = (col + 1 >= width_px) && (row + 1 >= height_px);
    if (col + 1 >= width_px) begin
      col = 0;
      if (row + 1 >= height_px) begin
        row  = 0;
        slot = (slot + 1 >= win_size) ? 0 : slot + 1;
        if (held + 1 < win_size) held++;
      end else begin
        row++;
      end
    end else begin
      col++;
    end
    if (exp_count == EXP_DEPTH) begin
      $display("%0t: expected-result store overflow", $time);
      errors_o++;
    end else begin
      exp_mem[exp_tail] = r;
      exp_tail = (exp_tail + 1) % EXP_DEPTH;
      exp_count++;
    end
  endtask

  // Inputs change only at rising edges, so the falling edge sees exactly
  // what the next rising edge will take.
  always @(negedge clk_i or negedge rst_ni) begin
    pix_result_t exp_r;
    if (!rst_ni) begin
      win_size  = WIN_RESET;
      width_px  = DIM_RESET;
      height_px = DIM_RESET;
      empty_ring();
      exp_head  = 0;
      exp_tail  = 0;
      exp_count = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) apply_register(reg_e'(cfg_index_i), cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) begin
        if (kind_e'(s_axis_tuser) == KIND_CLEAR) empty_ring();
        else predict_pixel(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (exp_count == 0) begin
          $display("%0t: unexpected transfer px=%h filt=%b last=%b", $time,
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
          errors_o++;
        end else begin
          exp_r = exp_mem[exp_head];
          exp_head = (exp_head + 1) % EXP_DEPTH;
          exp_count--;
          if (m_axis_tdata !== exp_r.px || m_axis_tuser !== exp_r.filt ||
              m_axis_tlast !== exp_r.last) begin
            $display("%0t: expected px=%h filt=%b last=%b, got px=%h filt=%b last=%b",
                     $time, exp_r.px, exp_r.filt, exp_r.last,
                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
            errors_o++;
          end
        end
      end
    end
  end

endmodule

// ----- verif/temporal_median_filter_core_test.sv -----
module temporal_median_filter_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tmf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid, s_axis_tready;
  logic [15:0]           s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid, m_axis_tready;
  logic [15:0]           m_axis_tdata;
  logic                  m_axis_tuser, m_axis_tlast;
  logic                  cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int                    errors, pending;
  int unsigned           cycles;
  bit                    no_gaps;  // phases without any idling on either side

  temporal_median_filter_core u_top (.*);

  temporal_median_filter_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes.
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: a random stall before each result, then ready held until
  // one transfer has happened.
  initial begin
    int unsigned gap;
    bit taken;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(negedge clk_i);
        taken = m_axis_tvalid;
        @(posedge clk_i);
      end while (!taken);
    end
  end

  // One item on the slave stream. tvalid stays high if the next item follows
  // without a gap.
  task automatic send_item(input kind_e kind, input logic [15:0] px);
    int unsigned gap;
    bit taken;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= px;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic write_reg(input reg_e idx, input logic [CFG_DATA_W-1:0] data);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Register writes only happen with the block drained. A clear transfer makes
  // no result, so a few extra cycles cover anything still in the pipeline.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] win, input logic [CFG_DATA_W-1:0] wid,
                           input logic [CFG_DATA_W-1:0] hgt);
    drain();
    if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, CFG_DATA_W'($urandom));
    write_reg(REG_WINDOW, win);
    write_reg(REG_WIDTH, wid);
    write_reg(REG_HEIGHT, hgt);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly pixels with the occasional history clear.
  task automatic run_pixels(input int unsigned n, input int unsigned clear_odds);
    for (int unsigned i = 0; i < n; i++) begin
      if (clear_odds != 0 && $urandom_range(1, clear_odds) == 1) send_item(KIND_CLEAR, 16'($urandom));
      else send_item(KIND_PIXEL, pick_pixel());
    end
  endtask

  initial begin
    int unsigned sent;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_NONE;
    cfg_data_i    = '0;
    no_gaps       = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: a huge frame, so everything passes through.
    send_item(KIND_PIXEL, 16'h0000);
    send_item(KIND_PIXEL, 16'hFFFF);
    send_item(KIND_CLEAR, 16'hFFFF);
    send_item(KIND_PIXEL, 16'h8000);

    // Window written as zero becomes 3, zero-sized frame becomes one pixel,
    // so the median kicks in on the third pixel.
    configure(11'd0, 11'd0, 11'd0);
    send_item(KIND_PIXEL, 16'h0000);
    send_item(KIND_PIXEL, 16'hFFFF);
    send_item(KIND_PIXEL, 16'h7FFF);
    send_item(KIND_PIXEL, 16'h8000);
    send_item(KIND_PIXEL, 16'h0001);
    send_item(KIND_CLEAR, 16'h0000);
    send_item(KIND_PIXEL, 16'h5555);
    send_item(KIND_PIXEL, 16'hAAAA);
    send_item(KIND_PIXEL, 16'h1234);

    // Window above the maximum saturates at 9; an unknown index does nothing.
    configure(11'h7FF, 11'd2, 11'd1);
    write_reg(REG_NONE, 11'h7FF);
    cfg_valid_i <= 1'b0;
    run_pixels(24, 0);

    // Widest line, with the window rounded from 2 to 3: the column counter
    // runs up to its top value and wraps into the next frame.
    no_gaps = 1'b1;
    configure(11'd2, 11'h7FF, 11'd1);
    run_pixels(1024 + 8, 0);
    no_gaps = 1'b0;

    sent = 0;
    while (sent < 700) begin
      int unsigned n;
      n = $urandom_range(50, 200);
      no_gaps = ($urandom_range(0, 4) == 0);
      configure(CFG_DATA_W'({$urandom_range(0, 127), 4'($urandom_range(0, 15))}),
                CFG_DATA_W'($urandom_range(0, 5)), CFG_DATA_W'($urandom_range(0, 4)));
      run_pixels(n, 60);
      sent += n;
    end
    no_gaps = 1'b0;

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/tmf_pkg.sv
sv/tmf_ram.sv
sv/tmf_ctrl.sv
sv/tmf_median.sv
sv/temporal_median_filter_core.sv
verif/temporal_median_filter_checker.sv
verif/temporal_median_filter_core_test.sv
